@@ hdl/esd_pkg.sv @@
// ----------------------------------------------------------------------------
// esd_pkg
// Shared types and character constants for the escape sequence decoder.
// ----------------------------------------------------------------------------
package esd_pkg;

  // Decoder mode between bytes
  typedef enum logic [1:0] {
    MODE_TEXT   = 2'd0,
    MODE_ESCAPE = 2'd1,
    MODE_OCTAL  = 2'd2
  } esd_mode_t;

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_LOWER_B   = 8'h62;
  localparam logic [7:0] CH_LOWER_F   = 8'h66;
  localparam logic [7:0] CH_LOWER_N   = 8'h6E;
  localparam logic [7:0] CH_LOWER_R   = 8'h72;
  localparam logic [7:0] CH_LOWER_T   = 8'h74;

  localparam logic [7:0] CTL_BS  = 8'h08;
  localparam logic [7:0] CTL_FF  = 8'h0C;
  localparam logic [7:0] CTL_LF  = 8'h0A;
  localparam logic [7:0] CTL_CR  = 8'h0D;
  localparam logic [7:0] CTL_TAB = 8'h09;

  // Octal digits '0'..'7' share these upper five bits
  localparam logic [4:0] OCTAL_HI = 5'b00110;
  localparam logic [1:0] OCTAL_MAX_DIGITS = 2'd3;

  // One decoded result
  typedef struct packed {
    logic [7:0] data;
    logic       byte_valid;
    logic       string_end;
  } esd_result_t;

  // Up to two results produced by one input byte
  typedef struct packed {
    logic [1:0]  count;
    esd_result_t res0;
    esd_result_t res1;
  } esd_dec_out_t;

endpackage

@@ hdl/esd_decode.sv @@
// ----------------------------------------------------------------------------
// esd_decode
// Per-byte escape decoding with the mode, digit count and octal value state.
// ----------------------------------------------------------------------------
module esd_decode (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  advance,
  input  logic [7:0]            in_byte,
  input  logic                  last_byte,
  output esd_pkg::esd_dec_out_t dec
);

  esd_pkg::esd_mode_t mode_r, mode_nxt;
  logic [1:0]         seen_r, seen_nxt;
  logic [7:0]         acc_r, acc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= esd_pkg::MODE_TEXT;
      seen_r <= 2'd0;
      acc_r  <= 8'd0;
    end else if (advance) begin
      mode_r <= mode_nxt;
      seen_r <= seen_nxt;
      acc_r  <= acc_nxt;
    end
  end

  always_comb begin
    logic       is_oct;
    logic [7:0] digit;
    logic [7:0] acc_shift;
    logic [1:0] seen_inc;
    logic       a_v, b_v, c_v;
    logic [7:0] a_d, b_d, c_d;
    logic [1:0] cnt;

    is_oct    = (in_byte[7:3] == esd_pkg::OCTAL_HI);
    digit     = {5'd0, in_byte[2:0]};
    acc_shift = {acc_r[4:0], 3'd0} + digit;
    seen_inc  = seen_r + 2'd1;

    mode_nxt = esd_pkg::MODE_TEXT;
    seen_nxt = seen_r;
    acc_nxt  = acc_r;
    a_v = 1'b0; a_d = 8'd0;
    b_v = 1'b0; b_d = 8'd0;
    c_v = 1'b0; c_d = 8'd0;

    unique case (mode_r)
      esd_pkg::MODE_ESCAPE: begin
        if (in_byte == 8'd0) begin
          // escaped zero byte: drop the pair
        end else if (is_oct) begin
          acc_nxt  = digit;
          seen_nxt = 2'd1;
          mode_nxt = esd_pkg::MODE_OCTAL;
        end else begin
          a_v = 1'b1;
          unique case (in_byte)
            esd_pkg::CH_LOWER_B: a_d = esd_pkg::CTL_BS;
            esd_pkg::CH_LOWER_F: a_d = esd_pkg::CTL_FF;
            esd_pkg::CH_LOWER_N: a_d = esd_pkg::CTL_LF;
            esd_pkg::CH_LOWER_R: a_d = esd_pkg::CTL_CR;
            esd_pkg::CH_LOWER_T: a_d = esd_pkg::CTL_TAB;
            default:             a_d = in_byte;
          endcase
        end
      end
      esd_pkg::MODE_OCTAL: begin
        if (is_oct && (seen_r < esd_pkg::OCTAL_MAX_DIGITS)) begin
          if (seen_inc == esd_pkg::OCTAL_MAX_DIGITS) begin
            a_v      = 1'b1;
            a_d      = acc_shift;
            seen_nxt = 2'd0;
            acc_nxt  = 8'd0;
          end else begin
            seen_nxt = seen_inc;
            acc_nxt  = acc_shift;
            mode_nxt = esd_pkg::MODE_OCTAL;
          end
        end else begin
          // flush the pending value, then treat the byte as text
          a_v      = 1'b1;
          a_d      = acc_r;
          seen_nxt = 2'd0;
          acc_nxt  = 8'd0;
          if (in_byte == esd_pkg::CH_BACKSLASH) begin
            mode_nxt = esd_pkg::MODE_ESCAPE;
          end else begin
            b_v = 1'b1;
            b_d = in_byte;
          end
        end
      end
      default: begin
        if (in_byte == esd_pkg::CH_BACKSLASH) begin
          mode_nxt = esd_pkg::MODE_ESCAPE;
        end else begin
          a_v = 1'b1;
          a_d = in_byte;
        end
      end
    endcase

    // string end flushes an open octal value
    if (last_byte && (mode_nxt == esd_pkg::MODE_OCTAL)) begin
      c_v = 1'b1;
      c_d = acc_nxt;
    end

    dec.res0 = '0;
    dec.res1 = '0;
    if (a_v) begin
      dec.res0 = '{data: a_d, byte_valid: 1'b1, string_end: 1'b0};
      if (b_v) begin
        dec.res1 = '{data: b_d, byte_valid: 1'b1, string_end: 1'b0};
      end
    end else if (b_v) begin
      dec.res0 = '{data: b_d, byte_valid: 1'b1, string_end: 1'b0};
    end else if (c_v) begin
      dec.res0 = '{data: c_d, byte_valid: 1'b1, string_end: 1'b0};
    end
    cnt = {1'b0, a_v} + {1'b0, b_v} + {1'b0, c_v};

    if (last_byte) begin
      if (cnt == 2'd0) begin
        dec.res0 = '{data: 8'd0, byte_valid: 1'b0, string_end: 1'b1};
        cnt      = 2'd1;
      end else if (cnt == 2'd1) begin
        dec.res0.string_end = 1'b1;
      end else begin
        dec.res1.string_end = 1'b1;
      end
      mode_nxt = esd_pkg::MODE_TEXT;
      seen_nxt = 2'd0;
      acc_nxt  = 8'd0;
    end
    dec.count = cnt;
  end

endmodule

@@ hdl/esd_out_queue.sv @@
// ----------------------------------------------------------------------------
// esd_out_queue
// Four-entry queue: takes up to two results a cycle, sends one when ready.
// ----------------------------------------------------------------------------
module esd_out_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  esd_pkg::esd_dec_out_t dec,
  output logic                  room,
  output logic                  out_valid,
  input  logic                  out_ready,
  output esd_pkg::esd_result_t  out_res
);

  esd_pkg::esd_result_t mem_r [4];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [2:0] count_r, count_nxt;
  logic       pop;
  logic [1:0] push_cnt;

  assign room      = (count_r <= 3'd2);
  assign out_valid = (count_r != 3'd0);
  assign out_res   = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  assign push_cnt  = push ? dec.count : 2'd0;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + push_cnt;
    rd_ptr_nxt = rd_ptr_r + {1'b0, pop};
    count_nxt  = count_r + {1'b0, push_cnt} - {2'd0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      count_r  <= 3'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= dec.res0;
    end
    if (push_cnt == 2'd2) begin
      mem_r[wr_ptr_r + 2'd1] <= dec.res1;
    end
  end

endmodule

@@ hdl/escape_sequence_decoder.sv @@
// Path: input stage register, decoder, result queue register, output.
// Throughput: one input byte per cycle while the queue has room; a byte
//   yielding two results (an octal value flushed by a following text byte)
//   writes both into the four-entry result queue.
// Reset: rst_n synchronous, active low; clears the decoder mode, the octal
//   state, the input stage and the queue.
// ----------------------------------------------------------------------------
// escape_sequence_decoder
// Undoes C-style escapes in a byte stream, one byte per transfer.
// ----------------------------------------------------------------------------
module escape_sequence_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,   // last_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tuser,  // [0] byte_valid
  output logic       out_tlast   // string_end
);

  // Input stage: holds one byte until the queue has room for its results
  logic       stage_v_r, stage_v_nxt;
  logic [7:0] stage_byte_r;
  logic       stage_last_r;

  logic                  room;
  logic                  advance;
  logic                  in_xfer;
  esd_pkg::esd_dec_out_t dec;
  esd_pkg::esd_result_t  out_res;

  // Advance the staged byte whenever the queue can take two results
  assign advance   = stage_v_r && room;
  assign in_tready = !stage_v_r || room;
  assign in_xfer   = in_tvalid && in_tready;

  always_comb begin
    stage_v_nxt = stage_v_r;
    if (in_xfer) begin
      stage_v_nxt = 1'b1;
    end else if (advance) begin
      stage_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= 1'b0;
    end else begin
      stage_v_r <= stage_v_nxt;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      stage_byte_r <= in_tdata;
      stage_last_r <= in_tlast;
    end
  end

  // Decode the staged byte; decoder state moves only when it advances
  esd_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .in_byte   (stage_byte_r),
    .last_byte (stage_last_r),
    .dec       (dec)
  );

  // Queue the results and send one per transfer
  esd_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (advance),
    .dec       (dec),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = out_res.data;
  assign out_tuser = out_res.byte_valid;
  assign out_tlast = out_res.string_end;

endmodule

@@ hdl/esd_checker.sv @@
// ----------------------------------------------------------------------------
// esd_checker
// Port-level checks for the escape sequence decoder, bound to the top level.
// ----------------------------------------------------------------------------
module esd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [7:0] in_tdata,
  input logic       in_tlast,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tuser,
  input logic       out_tlast
);

  // Queue empties on reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output valid dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("output payload changed while stalled");

  // A result without a byte only marks the end of a string
  a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tlast)
    else $error("empty result without string end");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == 8'd0)
    else $error("empty result with nonzero byte");

endmodule

bind escape_sequence_decoder esd_checker u_esd_checker (.*);
